/* hdl/tlrq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlrq_pkg
// Types and codes shared by the three-level ready queue.
// ---------------------------------------------------------------------------
package tlrq_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_PICK   = 2'd1;
   localparam logic [1:0] CMD_AGE    = 2'd2;

   localparam logic [1:0] LVL_ONE    = 2'd1;
   localparam logic [1:0] LVL_TWO    = 2'd2;
   localparam logic [1:0] LVL_THREE  = 2'd3;

   localparam logic [2:0] CSR_LEVEL1_FLOOR   = 3'd0;
   localparam logic [2:0] CSR_LEVEL2_FLOOR   = 3'd1;
   localparam logic [2:0] CSR_MAX_PRIORITY   = 3'd2;
   localparam logic [2:0] CSR_AGING_STEP     = 3'd3;
   localparam logic [2:0] CSR_WAIT_INCREMENT = 3'd4;
   localparam logic [2:0] CSR_WAIT_THRESHOLD = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  task_id;
      logic [7:0]  task_priority;
      logic [15:0] task_burst;
      logic [15:0] running_burst;
      logic [15:0] running_time;
   } req_type;

   typedef struct packed {
      logic [7:0] picked_id;
      logic       picked_valid;
      logic       preempt;
      logic       overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_ACT  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef enum logic [5:0] {
      PH_INS  = 6'b000001,
      PH_PICK = 6'b000010,
      PH_AGE  = 6'b000100,
      PH_SEL1 = 6'b001000,
      PH_SEL3 = 6'b010000,
      PH_SEL2 = 6'b100000
   } phase_type;

endpackage

/* hdl/three_level_ready_queue_with_aging.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// three_level_ready_queue_with_aging
// Task table in three priority levels with pick, insert and aging tick.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one command item (insert, pick, aging tick) on valid/ready.
//   rsp_* returns exactly one result item per command on valid/ready.
//   csr_* writes the six tuning registers; write only while the block idles.
// Operation: every insert, pick or aging command is worked by one scan unit
//   that walks the slot table one slot per cycle through a registered-read
//   memory. An insert or a pick takes one scan followed by the action state.
//   An aging tick takes one update scan, then one selection scan per
//   requeued or promoted entry plus one empty scan per level.
//   Unused command code: the result is valid in the cycle after accept.
// Only one item is in work: req_ready is high only while idle.
// Reset empties the table, zeroes the stamp counter and loads register
//   defaults. A stalled receiver holds the result and blocks new items.
// ---------------------------------------------------------------------------
module three_level_ready_queue_with_aging #(
   parameter int ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlrq_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import tlrq_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] slot;
      logic [1:0]       lvl;
      logic [15:0]      burst;
      logic [7:0]       id;
      logic [7:0]       prio;
      logic [15:0]      stamp;
   } best_type;

   // slot table
   logic [7:0]  mem_id    [ENTRIES];
   logic [7:0]  mem_prio  [ENTRIES];
   logic [15:0] mem_burst [ENTRIES];
   logic [15:0] mem_wait  [ENTRIES];
   logic [1:0]  mem_lvl   [ENTRIES];
   logic [15:0] mem_stamp [ENTRIES];

   state_type        state_ff;
   phase_type        phase_ff;
   req_type          req_ff;
   rsp_type          rsp_ff;
   best_type         best_ff;
   logic [IDX_W-1:0] scan_idx_ff;
   logic             scan_on_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_slot_ff;
   logic [ENTRIES-1:0] used_ff;
   logic [ENTRIES-1:0] mark_ff;
   logic [15:0]      counter_ff;

   logic [7:0]  level1_floor_ff, level2_floor_ff, max_priority_ff, aging_step_ff;
   logic [15:0] wait_increment_ff, wait_threshold_ff;

   logic [7:0]  rd_id_ff, rd_prio_ff;
   logic [15:0] rd_burst_ff, rd_wait_ff, rd_stamp_ff;
   logic [1:0]  rd_lvl_ff;

   // write port
   logic             we_id, we_prio, we_burst, we_wait, we_lvl, we_stamp;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wd_prio;
   logic [15:0]      wd_wait;
   logic [1:0]       wd_lvl;

   // compare unit
   logic [15:0] age_cur, age_best;
   logic        older, ahead, take, cand_used, cand_mark;
   // aging update
   logic [16:0] wait_sum;
   logic [15:0] wait_sat, new_wait;
   logic [8:0]  prio_sum;
   logic [7:0]  aged_prio, new_prio;
   logic        hit, mark_set;
   // insert
   logic [1:0]         ins_lvl;
   logic signed [17:0] bound;
   logic               ins_preempt;
   logic               act_stamp;
   logic               act_done;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data  = rsp_ff;

   assign cand_used = used_ff[rd_slot_ff];
   assign cand_mark = mark_ff[rd_slot_ff];
   assign age_cur   = counter_ff - rd_stamp_ff;
   assign age_best  = counter_ff - best_ff.stamp;
   assign older     = age_cur > age_best;

   always_comb begin
      if (rd_lvl_ff != best_ff.lvl) begin
         ahead = rd_lvl_ff < best_ff.lvl;
      end else begin
         case (rd_lvl_ff)
            LVL_ONE: ahead = (rd_burst_ff != best_ff.burst) ?
                             (rd_burst_ff < best_ff.burst) : older;
            LVL_TWO: ahead = (rd_id_ff != best_ff.id) ? (rd_id_ff < best_ff.id) : older;
            default: ahead = older;
         endcase
      end
   end

   always_comb begin
      case (phase_ff)
         PH_INS:  take = !cand_used && !best_ff.found;
         PH_PICK: take = cand_used && (!best_ff.found || ahead);
         PH_SEL1: take = cand_used && cand_mark && (rd_lvl_ff == LVL_ONE) &&
                         (!best_ff.found || ahead);
         PH_SEL3: take = cand_used && cand_mark && (rd_lvl_ff == LVL_THREE) &&
                         (!best_ff.found || ahead);
         PH_SEL2: take = cand_used && cand_mark && (rd_lvl_ff == LVL_TWO) &&
                         (!best_ff.found || ahead);
         default: take = 1'b0;
      endcase
   end

   // finish the command after this action, else rescan
   always_comb begin
      case (phase_ff)
         PH_AGE, PH_SEL1, PH_SEL3: act_done = 1'b0;
         PH_SEL2: act_done = !best_ff.found;
         default: act_done = 1'b1;
      endcase
   end

   // saturate wait, age priority, flag entries for later moves
   assign wait_sum  = {1'b0, rd_wait_ff} + {1'b0, wait_increment_ff};
   assign wait_sat  = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
   assign hit       = wait_sat > wait_threshold_ff;
   assign prio_sum  = {1'b0, rd_prio_ff} + {1'b0, aging_step_ff};
   assign aged_prio = (prio_sum > {1'b0, max_priority_ff}) ? max_priority_ff : prio_sum[7:0];
   assign new_prio  = hit ? aged_prio : rd_prio_ff;
   assign new_wait  = (hit && rd_lvl_ff == LVL_ONE) ? 16'd0 : wait_sat;
   assign mark_set  = cand_used && hit &&
                      ((rd_lvl_ff == LVL_ONE) || (rd_lvl_ff == LVL_TWO) ||
                       ((rd_lvl_ff == LVL_THREE) && (new_prio >= level2_floor_ff)));

   assign ins_lvl = (req_ff.task_priority >= level1_floor_ff) ? LVL_ONE :
                    (req_ff.task_priority >= level2_floor_ff) ? LVL_TWO : LVL_THREE;
   assign bound   = $signed({2'b00, req_ff.running_burst}) -
                    $signed({2'b00, req_ff.running_time});
   assign ins_preempt = (ins_lvl == LVL_ONE) && ($signed({2'b00, req_ff.task_burst}) < bound);

   assign act_stamp = (state_ff == ST_ACT) && best_ff.found &&
                      (phase_ff == PH_INS || phase_ff == PH_SEL1 ||
                       phase_ff == PH_SEL3 || phase_ff == PH_SEL2);

   always_comb begin
      we_id    = 1'b0;
      we_prio  = 1'b0;
      we_burst = 1'b0;
      we_wait  = 1'b0;
      we_lvl   = 1'b0;
      we_stamp = act_stamp;
      wr_addr  = best_ff.slot;
      wd_prio  = req_ff.task_priority;
      wd_wait  = 16'd0;
      wd_lvl   = ins_lvl;
      if (state_ff == ST_SCAN && phase_ff == PH_AGE && rd_vld_ff && cand_used) begin
         wr_addr = rd_slot_ff;
         we_prio = 1'b1;
         we_wait = 1'b1;
         wd_prio = new_prio;
         wd_wait = new_wait;
      end else if (state_ff == ST_ACT && best_ff.found) begin
         case (phase_ff)
            PH_INS: begin
               we_id    = 1'b1;
               we_prio  = 1'b1;
               we_burst = 1'b1;
               we_wait  = 1'b1;
               we_lvl   = 1'b1;
            end
            PH_SEL3: begin
               we_wait = 1'b1;
               we_lvl  = 1'b1;
               wd_lvl  = LVL_TWO;
            end
            PH_SEL2: begin
               we_wait = best_ff.prio >= level1_floor_ff;
               we_lvl  = best_ff.prio >= level1_floor_ff;
               wd_lvl  = LVL_ONE;
            end
            default: begin
               we_wait = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we_id)    mem_id[wr_addr]    <= req_ff.task_id;
      if (we_prio)  mem_prio[wr_addr]  <= wd_prio;
      if (we_burst) mem_burst[wr_addr] <= req_ff.task_burst;
      if (we_wait)  mem_wait[wr_addr]  <= wd_wait;
      if (we_lvl)   mem_lvl[wr_addr]   <= wd_lvl;
      if (we_stamp) mem_stamp[wr_addr] <= counter_ff;
      rd_id_ff    <= mem_id[scan_idx_ff];
      rd_prio_ff  <= mem_prio[scan_idx_ff];
      rd_burst_ff <= mem_burst[scan_idx_ff];
      rd_wait_ff  <= mem_wait[scan_idx_ff];
      rd_lvl_ff   <= mem_lvl[scan_idx_ff];
      rd_stamp_ff <= mem_stamp[scan_idx_ff];
      rd_slot_ff  <= scan_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level1_floor_ff   <= 8'd100;
         level2_floor_ff   <= 8'd50;
         max_priority_ff   <= 8'd149;
         aging_step_ff     <= 8'd10;
         wait_increment_ff <= 16'd100;
         wait_threshold_ff <= 16'd400;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEVEL1_FLOOR:   level1_floor_ff   <= csr_wdata[7:0];
            CSR_LEVEL2_FLOOR:   level2_floor_ff   <= csr_wdata[7:0];
            CSR_MAX_PRIORITY:   max_priority_ff   <= csr_wdata[7:0];
            CSR_AGING_STEP:     aging_step_ff     <= csr_wdata[7:0];
            CSR_WAIT_INCREMENT: wait_increment_ff <= csr_wdata;
            CSR_WAIT_THRESHOLD: wait_threshold_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_INS;
         scan_idx_ff <= '0;
         scan_on_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         used_ff     <= '0;
         mark_ff     <= '0;
         counter_ff  <= 16'd0;
         best_ff     <= '0;
         rsp_ff      <= '0;
         req_ff      <= '0;
      end else begin
         rd_vld_ff <= (state_ff == ST_SCAN) && scan_on_ff;
         if (act_stamp) begin
            counter_ff <= counter_ff + 16'd1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff      <= req_data;
                  rsp_ff      <= '0;
                  scan_idx_ff <= '0;
                  best_ff     <= '0;
                  case (req_data.cmd)
                     CMD_INSERT: begin
                        phase_ff   <= PH_INS;
                        scan_on_ff <= 1'b1;
                        state_ff   <= ST_SCAN;
                     end
                     CMD_PICK: begin
                        phase_ff   <= PH_PICK;
                        scan_on_ff <= 1'b1;
                        state_ff   <= ST_SCAN;
                     end
                     CMD_AGE: begin
                        phase_ff   <= PH_AGE;
                        scan_on_ff <= 1'b1;
                        state_ff   <= ST_SCAN;
                     end
                     default: begin
                        scan_on_ff <= 1'b0;
                        state_ff   <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (scan_on_ff) begin
                  if (scan_idx_ff == LAST) begin
                     scan_on_ff <= 1'b0;
                  end else begin
                     scan_idx_ff <= scan_idx_ff + 1'b1;
                  end
               end
               if (rd_vld_ff) begin
                  if (phase_ff == PH_AGE) begin
                     mark_ff[rd_slot_ff] <= mark_set;
                  end
                  if (take) begin
                     best_ff <= '{found: 1'b1, slot: rd_slot_ff, lvl: rd_lvl_ff,
                                  burst: rd_burst_ff, id: rd_id_ff, prio: rd_prio_ff,
                                  stamp: rd_stamp_ff};
                  end
                  if (rd_slot_ff == LAST) begin
                     state_ff <= ST_ACT;
                  end
               end
            end
            ST_ACT: begin
               // rescan in the same or the next phase unless the command is finished
               scan_idx_ff <= '0;
               best_ff     <= '0;
               scan_on_ff  <= !act_done;
               state_ff    <= act_done ? ST_DONE : ST_SCAN;
               if (best_ff.found) begin
                  mark_ff[best_ff.slot] <= 1'b0;
               end
               case (phase_ff)
                  PH_INS: begin
                     if (best_ff.found) begin
                        used_ff[best_ff.slot] <= 1'b1;
                        rsp_ff.preempt        <= ins_preempt;
                     end else begin
                        rsp_ff.overflow <= 1'b1;
                     end
                  end
                  PH_PICK: begin
                     if (best_ff.found) begin
                        used_ff[best_ff.slot] <= 1'b0;
                        rsp_ff.picked_id      <= best_ff.id;
                        rsp_ff.picked_valid   <= 1'b1;
                     end
                  end
                  PH_AGE: phase_ff <= PH_SEL1;
                  PH_SEL1: begin
                     if (!best_ff.found) phase_ff <= PH_SEL3;
                  end
                  PH_SEL3: begin
                     if (!best_ff.found) phase_ff <= PH_SEL2;
                  end
                  default: begin
                  end
               endcase
            end
            ST_DONE: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // hold off new items while a result waits
   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted while result pending");

   a_overflow_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> !rsp_data.preempt && !rsp_data.picked_valid)
      else $error("overflow combined with other flags");

   a_read_follows_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == ST_SCAN))
      else $error("read data valid outside scan");

   a_stamp_advances: assert property (@(posedge clock) disable iff (reset)
      act_stamp |=> counter_ff == $past(counter_ff) + 16'd1)
      else $error("stamp counter did not advance");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the three-level ready queue with aging.
// Inserts, picks, aging ticks and the unused code are sent in random bursts
// under several register settings. A scoreboard keeps its own copy of the
// slot table and checks every result item field by field, in order.
// ---------------------------------------------------------------------------
import tlrq_pkg::*;

class ready_queue_scoreboard;
   localparam int SLOTS = 32;

   bit [7:0]  l1_floor, l2_floor, prio_ceiling, prio_step;
   bit [15:0] wait_step, wait_limit;
   bit        used[SLOTS];
   bit        mark[SLOTS];
   bit [7:0]  ids[SLOTS];
   bit [7:0]  prio[SLOTS];
   bit [15:0] burst[SLOTS];
   bit [15:0] waited[SLOTS];
   bit [15:0] stamps[SLOTS];
   bit [1:0]  lvl[SLOTS];
   bit [15:0] arrivals;
   rsp_type   expected_q[$];
   int        errors;

   function new();
      l1_floor = 100; l2_floor = 50; prio_ceiling = 149; prio_step = 10;
      wait_step = 100; wait_limit = 400;
      arrivals = 0;
      errors = 0;
      foreach (used[s]) begin
         used[s] = 0;
         mark[s] = 0;
      end
   endfunction

   function void set_reg(bit [2:0] idx, bit [15:0] v);
      case (idx)
         CSR_LEVEL1_FLOOR:   l1_floor = v[7:0];
         CSR_LEVEL2_FLOOR:   l2_floor = v[7:0];
         CSR_MAX_PRIORITY:   prio_ceiling = v[7:0];
         CSR_AGING_STEP:     prio_step = v[7:0];
         CSR_WAIT_INCREMENT: wait_step = v;
         CSR_WAIT_THRESHOLD: wait_limit = v;
         default: ;
      endcase
   endfunction

   function bit older(int a, int b);
      bit [15:0] age_a, age_b;
      age_a = arrivals - stamps[a];
      age_b = arrivals - stamps[b];
      return age_a > age_b;
   endfunction

   function bit ahead(int a, int b);
      if (lvl[a] == LVL_ONE && burst[a] != burst[b]) return burst[a] < burst[b];
      if (lvl[a] == LVL_TWO && ids[a] != ids[b]) return ids[a] < ids[b];
      return older(a, b);
   endfunction

   function int head(bit [1:0] lv, bit need_mark);
      int best;
      best = -1;
      for (int s = 0; s < SLOTS; s++) begin
         if (!used[s] || lvl[s] != lv) continue;
         if (need_mark && !mark[s]) continue;
         if (best < 0 || ahead(s, best)) best = s;
      end
      return best;
   endfunction

   function void restamp(int s);
      stamps[s] = arrivals;
      arrivals = arrivals + 16'd1;
   endfunction

   function bit [7:0] aged(bit [7:0] p);
      int v;
      v = p + prio_step;
      return (v > prio_ceiling) ? prio_ceiling : v[7:0];
   endfunction

   function void age_table();
      int s;
      int w;
      foreach (mark[i]) mark[i] = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!used[i]) continue;
         w = waited[i] + wait_step;
         waited[i] = (w > 65535) ? 16'hFFFF : w[15:0];
         if (waited[i] > wait_limit) begin
            prio[i] = aged(prio[i]);
            if (lvl[i] == LVL_ONE) begin
               waited[i] = 0;
               mark[i] = 1;
            end
         end
      end
      for (s = head(LVL_ONE, 1); s >= 0; s = head(LVL_ONE, 1)) begin
         mark[s] = 0;
         restamp(s);
      end
      foreach (mark[i])
         mark[i] = used[i] && lvl[i] == LVL_THREE && prio[i] >= l2_floor
                   && waited[i] > wait_limit;
      for (s = head(LVL_THREE, 1); s >= 0; s = head(LVL_THREE, 1)) begin
         mark[s] = 0;
         waited[s] = 0;
         lvl[s] = LVL_TWO;
         restamp(s);
      end
      foreach (mark[i])
         mark[i] = used[i] && lvl[i] == LVL_TWO && waited[i] > wait_limit;
      for (s = head(LVL_TWO, 1); s >= 0; s = head(LVL_TWO, 1)) begin
         mark[s] = 0;
         if (prio[s] >= l1_floor) begin
            waited[s] = 0;
            lvl[s] = LVL_ONE;
         end
         restamp(s);
      end
   endfunction

   // work out the result of an accepted item and advance the table
   function void note(req_type r);
      rsp_type e;
      int slot, s;
      e = '0;
      slot = -1;
      if (r.cmd == CMD_INSERT) begin
         for (int i = 0; i < SLOTS; i++)
            if (!used[i]) begin
               slot = i;
               break;
            end
         if (slot < 0) begin
            e.overflow = 1;
         end else begin
            used[slot] = 1;
            ids[slot] = r.task_id;
            prio[slot] = r.task_priority;
            burst[slot] = r.task_burst;
            waited[slot] = 0;
            if (r.task_priority >= l1_floor) begin
               lvl[slot] = LVL_ONE;
               if (int'(r.task_burst) < int'(r.running_burst) - int'(r.running_time))
                  e.preempt = 1;
            end else if (r.task_priority >= l2_floor) begin
               lvl[slot] = LVL_TWO;
            end else begin
               lvl[slot] = LVL_THREE;
            end
            restamp(slot);
         end
      end else if (r.cmd == CMD_PICK) begin
         for (int lv = 1; lv <= 3; lv++) begin
            s = head(lv[1:0], 0);
            if (s >= 0) begin
               e.picked_id = ids[s];
               e.picked_valid = 1;
               used[s] = 0;
               break;
            end
         end
      end else if (r.cmd == CMD_AGE) begin
         age_table();
      end
      expected_q.push_back(e);
   endfunction

   function void check(rsp_type got);
      rsp_type e;
      if (expected_q.size() == 0) begin
         errors++;
         if (errors <= 10) $display("result item with nothing expected: %p", got);
         return;
      end
      e = expected_q.pop_front();
      if (got.picked_id !== e.picked_id || got.picked_valid !== e.picked_valid ||
          got.preempt !== e.preempt || got.overflow !== e.overflow) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected id %0d valid %0b preempt %0b overflow %0b, got id %0d valid %0b preempt %0b overflow %0b",
                     e.picked_id, e.picked_valid, e.preempt, e.overflow,
                     got.picked_id, got.picked_valid, got.preempt, got.overflow);
      end
   endfunction

   function void close_out();
      if (expected_q.size() != 0) begin
         errors++;
         $display("%0d result items never arrived", expected_q.size());
      end
   endfunction
endclass

module tb;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   ready_queue_scoreboard sb;
   int stall_mode = 0;
   int rx_cycle = 0;

   three_level_ready_queue_with_aging u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #200ms;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: drive rsp_ready by one of four randomly chosen stall patterns
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 200 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (rx_cycle % 16) < 11;
         default: rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_data);

   task automatic send_item(req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note(r);
   endtask

   task automatic idle_gap(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(int l1, int l2, int mp, int st, int wi, int wt);
      write_reg(CSR_LEVEL1_FLOOR, 16'(l1));
      write_reg(CSR_LEVEL2_FLOOR, 16'(l2));
      write_reg(CSR_MAX_PRIORITY, 16'(mp));
      write_reg(CSR_AGING_STEP, 16'(st));
      write_reg(CSR_WAIT_INCREMENT, 16'(wi));
      write_reg(CSR_WAIT_THRESHOLD, 16'(wt));
   endtask

   function automatic req_type make_req(logic [1:0] c, int id, int p, int b, int rb, int rt);
      req_type r;
      r.cmd = c;
      r.task_id = 8'(id);
      r.task_priority = 8'(p);
      r.task_burst = 16'(b);
      r.running_burst = 16'(rb);
      r.running_time = 16'(rt);
      return r;
   endfunction

   function automatic req_type random_req(int insert_pct);
      req_type r;
      int roll;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) r.cmd = CMD_INSERT;
      else if (roll < insert_pct + (100 - insert_pct) * 6 / 10) r.cmd = CMD_PICK;
      else if (roll < 97) r.cmd = CMD_AGE;
      else r.cmd = CMD_UNUSED;
      // crowd keys together so that ties and floors are hit
      if ($urandom_range(0, 1)) r.task_burst = 16'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) r.task_id = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 1)) r.task_priority = 8'($urandom_range(40, 110));
      return r;
   endfunction

   task automatic random_run(int count, int insert_pct, bit hold_mid);
      int burst_left;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
         end
         burst_left--;
         send_item(random_req(insert_pct));
         if (hold_mid && i == count / 2) drain_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pick, unused code, floors, preemption edges, ageing
      send_item(make_req(CMD_PICK, 0, 0, 0, 0, 0));
      send_item(make_req(CMD_UNUSED, 255, 255, 65535, 65535, 65535));
      send_item(make_req(CMD_INSERT, 0, 255, 0, 65535, 0));
      send_item(make_req(CMD_INSERT, 255, 100, 65535, 0, 65535));
      send_item(make_req(CMD_INSERT, 7, 100, 5, 10, 20));
      send_item(make_req(CMD_INSERT, 8, 150, 5, 16, 10));
      send_item(make_req(CMD_INSERT, 9, 99, 3, 0, 0));
      send_item(make_req(CMD_INSERT, 4, 99, 3, 0, 0));
      send_item(make_req(CMD_INSERT, 4, 50, 3, 0, 0));
      send_item(make_req(CMD_INSERT, 1, 49, 3, 0, 0));
      send_item(make_req(CMD_INSERT, 2, 0, 3, 0, 0));
      send_item(make_req(CMD_INSERT, 3, 45, 3, 0, 0));
      repeat (6) send_item(make_req(CMD_AGE, 0, 0, 0, 0, 0));
      repeat (7) send_item(make_req(CMD_PICK, 0, 0, 0, 0, 0));
      drain_results();

      random_run(140, 45, 1);
      drain_results();
      write_all(255, 255, 255, 255, 65535, 0);
      random_run(110, 80, 0);
      drain_results();
      write_all(0, 0, 0, 0, 0, 65535);
      random_run(110, 50, 0);
      drain_results();
      for (int ph = 0; ph < 3; ph++) begin
         write_all($urandom_range(60, 200), $urandom_range(0, 60), $urandom_range(0, 255),
                   $urandom_range(0, 60), $urandom_range(1, 300), $urandom_range(0, 1000));
         random_run(140, $urandom_range(35, 75), 0);
         drain_results();
      end
      repeat (10) @(posedge clock);

      sb.close_out();
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
